### src/ipid_pkg.sv
package ipid_pkg;

  // fixed widths of the loop
  localparam int TEMP_W  = 16;
  localparam int SP_W    = 8;
  localparam int COEF_W  = 32;
  localparam int ERR_W   = 24;
  localparam int ACC_W   = 48;
  localparam int DRIVE_W = 20;
  localparam int PROD_W  = COEF_W + ERR_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int COEF_FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [SP_W-1:0]          SETPOINT_RST   = 8'd37;
  localparam logic signed [COEF_W-1:0] COEF_CUR_RST   = 32'sd1508311;
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -32'sd2030633;
  localparam logic signed [COEF_W-1:0] COEF_BPREV_RST = 32'sd524288;

  // drive limits in q4.16
  localparam logic [DRIVE_W-1:0] DRIVE_ONE  = 20'd65536;
  localparam logic [DRIVE_W-1:0] DRIVE_NINE = 20'd589824;
  localparam logic [DRIVE_W-1:0] DRIVE_TEN  = 20'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 4'd0,
    REG_COEF_CUR   = 4'd1,
    REG_COEF_PREV  = 4'd2,
    REG_COEF_BPREV = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_CUR   = 2'd0,
    MUL_PREV  = 2'd1,
    MUL_BPREV = 2'd2
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;       // capture the new error
    logic     mul_en;     // register one product
    mul_sel_t mul_sel;
    logic     sum_first;  // sum takes the product
    logic     sum_add;    // sum adds the product
    logic     round;      // scale the sum to q16.16
    logic     sat;        // saturating update, shift error history
    logic     clamp;      // clamp into the drive range
    logic     emit;       // load the result register
    logic     upd;        // updated flag for the beat
  } ipid_cmd_t;

endpackage

### src/ipid_dp.sv
module ipid_dp #(
  parameter int COEF_FRAC_BITS = ipid_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ipid_pkg::ipid_cmd_t                   cmd,
  input  logic signed [ipid_pkg::TEMP_W-1:0]    temperature,
  input  logic                                  cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [ipid_pkg::DRIVE_W-1:0]          drive_level,
  output logic [ipid_pkg::DRIVE_W-1:0]          firing_delay_ms,
  output logic                                  updated
);

  localparam int SH     = COEF_FRAC_BITS - 8;
  localparam int SUM_W  = ipid_pkg::SUM_W;
  localparam int ACC_W  = ipid_pkg::ACC_W;
  localparam int WIDE_W = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = (SUM_W'(1) << SH) >> 1;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX =
    {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN =
    {{(WIDE_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(ipid_pkg::DRIVE_ONE);
  localparam logic signed [ACC_W-1:0] ACC_NINE = ACC_W'(ipid_pkg::DRIVE_NINE);

  logic [ipid_pkg::SP_W-1:0]                 setpoint_degrees;
  logic signed [ipid_pkg::COEF_W-1:0]        coef_current;
  logic signed [ipid_pkg::COEF_W-1:0]        coef_previous;
  logic signed [ipid_pkg::COEF_W-1:0]        coef_before_previous;

  logic signed [ipid_pkg::ERR_W-1:0]         error_current;
  logic signed [ipid_pkg::ERR_W-1:0]         error_previous;
  logic signed [ipid_pkg::ERR_W-1:0]         error_before_previous;
  logic signed [ACC_W-1:0]                   unclamped_output;
  logic [ipid_pkg::DRIVE_W-1:0]              last_drive;

  logic signed [ipid_pkg::COEF_W-1:0]        mul_a;
  logic signed [ipid_pkg::ERR_W-1:0]         mul_b;
  logic signed [ipid_pkg::PROD_W-1:0]        prod;
  logic signed [SUM_W-1:0]                   sum;
  logic signed [SUM_W-1:0]                   sum_rnd;
  logic signed [SUM_W-1:0]                   inc;
  logic signed [WIDE_W-1:0]                  acc_wide;
  logic signed [ipid_pkg::ERR_W-1:0]         error_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_degrees     <= ipid_pkg::SETPOINT_RST;
      coef_current         <= ipid_pkg::COEF_CUR_RST;
      coef_previous        <= ipid_pkg::COEF_PREV_RST;
      coef_before_previous <= ipid_pkg::COEF_BPREV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipid_pkg::REG_SETPOINT:   setpoint_degrees     <= cfg_data[ipid_pkg::SP_W-1:0];
        ipid_pkg::REG_COEF_CUR:   coef_current         <= $signed(cfg_data);
        ipid_pkg::REG_COEF_PREV:  coef_previous        <= $signed(cfg_data);
        ipid_pkg::REG_COEF_BPREV: coef_before_previous <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // error in q16.8
  assign error_next = $signed({8'b0, setpoint_degrees, 8'b0})
                    - {{(ipid_pkg::ERR_W-ipid_pkg::TEMP_W){temperature[ipid_pkg::TEMP_W-1]}},
                       temperature};

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      ipid_pkg::MUL_CUR: begin
        mul_a = coef_current;
        mul_b = error_current;
      end
      ipid_pkg::MUL_PREV: begin
        mul_a = coef_previous;
        mul_b = error_previous;
      end
      ipid_pkg::MUL_BPREV: begin
        mul_a = coef_before_previous;
        mul_b = error_before_previous;
      end
      default: begin
        mul_a = coef_current;
        mul_b = error_current;
      end
    endcase
  end

  assign sum_rnd  = sum + HALF;
  assign acc_wide = WIDE_W'(unclamped_output) + WIDE_W'(inc);

  always_ff @(posedge clk) begin
    if (cmd.load) error_current <= error_next;
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.sum_first) sum <= SUM_W'(prod);
    else if (cmd.sum_add) sum <= sum + SUM_W'(prod);
    if (cmd.round) inc <= sum_rnd >>> SH;
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_previous        <= '0;
      error_before_previous <= '0;
      unclamped_output      <= '0;
      last_drive            <= ipid_pkg::DRIVE_ONE;
    end else begin
      if (cmd.sat) begin
        error_before_previous <= error_previous;
        error_previous        <= error_current;
        priority if (acc_wide > WIDE_MAX) unclamped_output <= WIDE_MAX[ACC_W-1:0];
        else if (acc_wide < WIDE_MIN)     unclamped_output <= WIDE_MIN[ACC_W-1:0];
        else                              unclamped_output <= acc_wide[ACC_W-1:0];
      end
      if (cmd.clamp) begin
        priority if (unclamped_output > ACC_NINE) last_drive <= ipid_pkg::DRIVE_NINE;
        else if (unclamped_output <= ACC_ONE)     last_drive <= ipid_pkg::DRIVE_ONE;
        else last_drive <= unclamped_output[ipid_pkg::DRIVE_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      drive_level     <= last_drive;
      firing_delay_ms <= ipid_pkg::DRIVE_TEN - last_drive;
      updated         <= cmd.upd;
    end
  end

endmodule

### src/ipid_ctrl.sv
module ipid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                sample_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ipid_pkg::ipid_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_ROUND, S_SAT, S_CLAMP, S_EMIT
  } state_t;

  state_t state;
  logic   upd;
  logic   in_take;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = ipid_pkg::MUL_CUR;
    cmd.upd     = upd;
    unique case (state)
      S_IDLE:  cmd.load = in_take && sample_valid;
      S_MUL0:  cmd.mul_en = 1'b1;
      S_MUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = ipid_pkg::MUL_PREV;
        cmd.sum_first = 1'b1;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ipid_pkg::MUL_BPREV;
        cmd.sum_add = 1'b1;
      end
      S_SUM:   cmd.sum_add = 1'b1;
      S_ROUND: cmd.round = 1'b1;
      S_SAT:   cmd.sat = 1'b1;
      S_CLAMP: cmd.clamp = 1'b1;
      S_EMIT:  cmd.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      upd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new beat wins over the one just taken
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            upd   <= sample_valid;
            state <= sample_valid ? S_MUL0 : S_EMIT;
          end
        end
        S_MUL0:  state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_SUM;
        S_SUM:   state <= S_ROUND;
        S_ROUND: state <= S_SAT;
        S_SAT:   state <= S_CLAMP;
        S_CLAMP: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/incremental_pid_heater_drive.sv
// a valid sample passes through the multiply, sum, round, saturate, clamp and emit steps before
//   its result beat, an invalid one goes straight to emit; in_stall holds off a new sample
//   until emit is done, and the single shared 32x24 multiplier takes the three products in turn
// a result waiting on out_stall holds the sequencer in its emit step until taken
// reset (rst, synchronous): registers to defaults, error history and output to zero,
//   drive to 1.0, no result pending
module incremental_pid_heater_drive #(
  parameter int COEF_FRAC_BITS = ipid_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ipid_pkg::TEMP_W-1:0]  temperature,
  input  logic                                sample_valid,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ipid_pkg::DRIVE_W-1:0]        drive_level,
  output logic [ipid_pkg::DRIVE_W-1:0]        firing_delay_ms,
  output logic                                updated,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ipid_pkg::ipid_cmd_t cmd;

  // register writes are always taken; unknown indexes are dropped in the datapath
  assign cfg_ready = 1'b1;

  // sequencer (valid sample): accept, three multiply steps, sum, round, saturate, clamp, emit
  ipid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .sample_valid (sample_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  // coefficients, error history, accumulator and the result register
  ipid_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .temperature     (temperature),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .drive_level     (drive_level),
    .firing_delay_ms (firing_delay_ms),
    .updated         (updated)
  );

endmodule

### src/ipid_chk.sv
module ipid_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ipid_pkg::DRIVE_W-1:0]       drive_level,
  input logic [ipid_pkg::DRIVE_W-1:0]       firing_delay_ms
);

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sample accepted while another is in flight");

  // drive and delay always add up to ten
  a_sum_ten: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, drive_level} + {1'b0, firing_delay_ms})
                  == {1'b0, ipid_pkg::DRIVE_TEN})
    else $error("drive and firing delay do not add up to ten");

  // drive stays within one to nine
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_level >= ipid_pkg::DRIVE_ONE && drive_level <= ipid_pkg::DRIVE_NINE)
    else $error("drive out of range");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_level) && $stable(firing_delay_ms))
    else $error("stalled result beat changed");

endmodule

bind incremental_pid_heater_drive ipid_chk u_ipid_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .drive_level     (drive_level),
  .firing_delay_ms (firing_delay_ms)
);
